// ===== hw/rtl/ile_pkg.sv =====
// ----------------------------------------------------------------------------
// ile_pkg
// Shared types and codes for the indexed list engine.
// ----------------------------------------------------------------------------
`default_nettype none
package ile_pkg;
    localparam int DEPTH_DEF       = 32;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam logic [3:0] REQ_PUSH_FRONT = 4'd0;
    localparam logic [3:0] REQ_PUSH_BACK  = 4'd1;
    localparam logic [3:0] REQ_INSERT     = 4'd2;
    localparam logic [3:0] REQ_POP_FRONT  = 4'd3;
    localparam logic [3:0] REQ_POP_BACK   = 4'd4;
    localparam logic [3:0] REQ_REMOVE     = 4'd5;
    localparam logic [3:0] REQ_SORT_UP    = 4'd6;
    localparam logic [3:0] REQ_SORT_DOWN  = 4'd7;
    localparam logic [3:0] REQ_READ_ALL   = 4'd8;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BADPOS = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    typedef enum logic [1:0] {
        OP_HOLD  = 2'd0,
        OP_LEFT  = 2'd1,
        OP_RIGHT = 2'd2,
        OP_NEW   = 2'd3
    } t_cell_op;
endpackage
`default_nettype wire

// ===== hw/rtl/indexed_list_engine.sv =====
// Push, insert, pop, remove and clear give their result in the cycle after start is taken.
// Sort runs DEPTH odd-even compare-swap passes over the cell row, then strobes its result.
// Read all rotates the whole row, one element per cycle from cell 0; busy until the rotation ends.
// Other requests are taken one per cycle; sort and read hold busy and take no request until done.
// Reset: synchronous active low clears the count, step, state and strobe; cell data is undefined.
// Results are strobed for one cycle and the receiver cannot stall.
// ----------------------------------------------------------------------------
// indexed_list_engine
// Ordered list of signed values kept in a row of shifting cells.
// ----------------------------------------------------------------------------
`default_nettype none
module indexed_list_engine #(
    parameter int DEPTH       = ile_pkg::DEPTH_DEF,
    parameter int VALUE_WIDTH = ile_pkg::VALUE_WIDTH_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         start,
    output logic        busy,
    input  wire  [3:0]  i_req_type,
    input  wire  [31:0] i_value,
    input  wire  [5:0]  i_position,
    input  wire         i_clear_all,
    output logic        o_strobe,
    output logic [1:0]  o_status,
    output logic [31:0] o_element,
    output logic        o_element_valid,
    output logic [5:0]  o_count,
    output logic        o_last
);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = $clog2(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SORT = 3'b010,
        S_READ = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [SW-1:0] r_step, n_step;
    logic          r_desc, n_desc;
    logic          r_strobe, n_strobe;
    logic [1:0]    r_status, n_status;
    logic [31:0]   r_elem, n_elem;
    logic          r_ev, n_ev;
    logic          r_last, n_last;

    ile_pkg::t_cell_op      w_op [DEPTH];
    logic [VALUE_WIDTH-1:0] w_val [DEPTH];
    logic                   w_swap [DEPTH-1];
    logic signed [VALUE_WIDTH-1:0] w_new;
    logic [CW-1:0] w_c;
    logic          w_accept;

    assign w_new    = VALUE_WIDTH'($signed(i_value));
    assign w_accept = start && (r_state == S_IDLE);
    assign w_c      = i_clear_all ? '0 : r_count;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            ile_cell #(.VALUE_WIDTH(VALUE_WIDTH)) u_cell (
                .i_clk   (i_clk),
                .i_op    (w_op[g]),
                .i_left  (w_val[(g + DEPTH - 1) % DEPTH]),
                .i_right (w_val[(g + 1) % DEPTH]),
                .i_new   (w_new),
                .o_value (w_val[g])
            );
        end
    endgenerate

    always_comb begin
        for (int i = 0; i < DEPTH - 1; i++) begin
            if ((i % 2 == int'(r_step[0])) && (i + 1 < int'(r_count))) begin
                w_swap[i] = r_desc ? ($signed(w_val[i]) < $signed(w_val[i+1]))
                                   : ($signed(w_val[i]) > $signed(w_val[i+1]));
            end else begin
                w_swap[i] = 1'b0;
            end
        end
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_step   = r_step;
        n_desc   = r_desc;
        n_strobe = 1'b0;
        n_status = ile_pkg::ST_OK;
        n_elem   = '0;
        n_ev     = 1'b0;
        n_last   = 1'b1;
        for (int i = 0; i < DEPTH; i++) w_op[i] = ile_pkg::OP_HOLD;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_count  = w_c;
                    n_strobe = 1'b1;
                    n_step   = '0;
                    case (i_req_type)
                        ile_pkg::REQ_PUSH_FRONT, ile_pkg::REQ_PUSH_BACK,
                        ile_pkg::REQ_INSERT: begin
                            if (i_req_type == ile_pkg::REQ_INSERT &&
                                int'(i_position) > int'(w_c)) begin
                                n_status = ile_pkg::ST_BADPOS;
                            end else if (int'(w_c) >= DEPTH) begin
                                n_status = ile_pkg::ST_FULL;
                            end else begin
                                for (int i = 0; i < DEPTH; i++) begin
                                    int p;
                                    p = (i_req_type == ile_pkg::REQ_PUSH_FRONT) ? 0 :
                                        (i_req_type == ile_pkg::REQ_PUSH_BACK) ? int'(w_c) :
                                        int'(i_position);
                                    if (i == p) w_op[i] = ile_pkg::OP_NEW;
                                    else if (i > p) w_op[i] = ile_pkg::OP_LEFT;
                                end
                                n_count = w_c + CW'(1);
                            end
                        end
                        ile_pkg::REQ_POP_FRONT, ile_pkg::REQ_POP_BACK,
                        ile_pkg::REQ_REMOVE: begin
                            if (w_c == '0) begin
                                n_status = ile_pkg::ST_EMPTY;
                            end else if (i_req_type == ile_pkg::REQ_REMOVE &&
                                         int'(i_position) >= int'(w_c)) begin
                                n_status = ile_pkg::ST_BADPOS;
                            end else begin
                                if (i_req_type != ile_pkg::REQ_POP_BACK) begin
                                    for (int i = 0; i < DEPTH - 1; i++) begin
                                        if ((i_req_type == ile_pkg::REQ_POP_FRONT) ||
                                            i >= int'(i_position))
                                            w_op[i] = ile_pkg::OP_RIGHT;
                                    end
                                end
                                n_count = w_c - CW'(1);
                            end
                        end
                        ile_pkg::REQ_SORT_UP, ile_pkg::REQ_SORT_DOWN: begin
                            n_strobe = 1'b0;
                            n_desc   = (i_req_type == ile_pkg::REQ_SORT_DOWN);
                            n_state  = S_SORT;
                        end
                        ile_pkg::REQ_READ_ALL: begin
                            if (w_c != '0) begin
                                n_strobe = 1'b0;
                                n_state  = S_READ;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SORT: begin
                for (int i = 0; i < DEPTH - 1; i++) begin
                    if (w_swap[i]) begin
                        w_op[i]   = ile_pkg::OP_RIGHT;
                        w_op[i+1] = ile_pkg::OP_LEFT;
                    end
                end
                n_step = r_step + SW'(1);
                if (int'(r_step) == DEPTH - 1) begin
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_READ: begin
                for (int i = 0; i < DEPTH; i++) w_op[i] = ile_pkg::OP_RIGHT;
                n_step = r_step + SW'(1);
                if (int'(r_step) < int'(r_count)) begin
                    n_strobe = 1'b1;
                    n_ev     = 1'b1;
                    n_elem   = 32'($signed(w_val[0]));
                    n_last   = (int'(r_step) + 1 == int'(r_count));
                end
                if (int'(r_step) == DEPTH - 1) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_step   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_step   <= n_step;
            r_strobe <= n_strobe;
        end
        r_desc   <= n_desc;
        r_status <= n_status;
        r_elem   <= n_elem;
        r_ev     <= n_ev;
        r_last   <= n_last;
    end

    assign busy            = (r_state != S_IDLE);
    assign o_strobe        = r_strobe;
    assign o_status        = r_status;
    assign o_element       = r_elem;
    assign o_element_valid = r_ev;
    assign o_count         = 6'(r_count);
    assign o_last          = r_last;
endmodule
`default_nettype wire

// ===== hw/rtl/ile_cell.sv =====
// ----------------------------------------------------------------------------
// ile_cell
// One list slot: holds, or takes its left, right or a new value.
// ----------------------------------------------------------------------------
`default_nettype none
module ile_cell #(
    parameter int VALUE_WIDTH = ile_pkg::VALUE_WIDTH_DEF
) (
    input  wire                    i_clk,
    input  ile_pkg::t_cell_op      i_op,
    input  wire  [VALUE_WIDTH-1:0] i_left,
    input  wire  [VALUE_WIDTH-1:0] i_right,
    input  wire  [VALUE_WIDTH-1:0] i_new,
    output logic [VALUE_WIDTH-1:0] o_value
);
    logic [VALUE_WIDTH-1:0] r_value;
    logic [VALUE_WIDTH-1:0] n_value;

    always_comb begin
        case (i_op)
            ile_pkg::OP_LEFT:  n_value = i_left;
            ile_pkg::OP_RIGHT: n_value = i_right;
            ile_pkg::OP_NEW:   n_value = i_new;
            default:           n_value = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
endmodule
`default_nettype wire

// ===== hw/rtl/ile_checker.sv =====
// ----------------------------------------------------------------------------
// ile_props
// Port-level checks for the indexed list engine.
// ----------------------------------------------------------------------------
`default_nettype none
module ile_props (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        busy,
    input wire        o_strobe,
    input wire [1:0]  o_status,
    input wire        o_element_valid,
    input wire        o_last
);
    a_ev_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_element_valid |-> o_status == ile_pkg::ST_OK)
        else $error("element item with bad status");
    a_read_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |=> o_strobe && o_element_valid)
        else $error("read-out broke before last");
    a_notlast_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |-> busy)
        else $error("idle during read-out");
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe && !busy)
        else $error("activity after reset");
endmodule

bind indexed_list_engine ile_props u_ile_props (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .busy            (busy),
    .o_strobe        (o_strobe),
    .o_status        (o_status),
    .o_element_valid (o_element_valid),
    .o_last          (o_last)
);
`default_nettype wire
